[src/ofp_pkg.sv]
// Shared types and constants for the OLED page framebuffer packer.
package ofp_pkg;

	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_CLEAR  = 2'd1;
	localparam logic [1:0] KIND_SEND   = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [7:0] OPC_COL_RANGE  = 8'h21;
	localparam logic [7:0] OPC_PAGE_RANGE = 8'h22;
	localparam int         ROWS_PER_PAGE  = 8;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] pixel_x;
		logic [5:0] pixel_y;
		logic       pixel_on;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       last_of_frame;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WRITE,
		ST_CMD,
		ST_READ,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic clr_init;
		logic clr_step;
		logic pix_write;
		logic emit_cmd;
		logic rd_step;
		logic emit_data;
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_data;
		logic clr_last;
		logic bit_last;
	} stat_t;

endpackage

[src/ofp_ctrl.sv]
// Controller state machine of the OLED page framebuffer packer.
module ofp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    kind,
	input  ofp_pkg::stat_t stat,
	output logic          busy,
	output ofp_pkg::ctrl_t ctrl
);
	import ofp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// The pixel store is swept clear after reset.
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (kind)
						KIND_WRITE: state_d = ST_WRITE;
						KIND_CLEAR: state_d = ST_CLEAR;
						KIND_SEND:  state_d = stat.in_data ? ST_READ : ST_CMD;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_WRITE:  state_d = ST_IDLE;
			ST_CMD:    state_d = ST_IDLE;
			ST_READ: begin
				if (stat.bit_last) state_d = ST_FINISH;
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				ctrl.load     = start;
				ctrl.clr_init = start && (kind == KIND_CLEAR);
			end
			ST_CLEAR:  ctrl.clr_step  = 1'b1;
			ST_WRITE:  ctrl.pix_write = 1'b1;
			ST_CMD:    ctrl.emit_cmd  = 1'b1;
			ST_READ:   ctrl.rd_step   = 1'b1;
			ST_FINISH: ctrl.emit_data = 1'b1;
			default:   ctrl = '0;
		endcase
	end

endmodule

[src/ofp_datapath.sv]
// Datapath of the OLED page framebuffer packer: pixel store, transfer position, output.
module ofp_datapath #(
	parameter int WIDTH  = 128,
	parameter int HEIGHT = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ofp_pkg::item_t   item,
	input  logic             cfg_we,
	input  logic             cfg_data,
	input  ofp_pkg::ctrl_t   ctrl,
	output ofp_pkg::stat_t   stat,
	output logic             done,
	output ofp_pkg::result_t result
);
	import ofp_pkg::*;

	localparam int PAGES = (HEIGHT + 7) / 8;
	localparam int XW    = $clog2(WIDTH);
	localparam int YW    = $clog2(HEIGHT);
	localparam int AW    = XW + YW;
	localparam int DEPTH = 1 << AW;
	localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int SYW   = PGW + $clog2(ROWS_PER_PAGE);

	localparam logic [2:0] CMD_COL_OP     = 3'd0;
	localparam logic [2:0] CMD_COL_START  = 3'd1;
	localparam logic [2:0] CMD_COL_END    = 3'd2;
	localparam logic [2:0] CMD_PAGE_OP    = 3'd3;
	localparam logic [2:0] CMD_PAGE_START = 3'd4;
	localparam logic [2:0] CMD_PAGE_END   = 3'd5;

	item_t           item_q;
	logic            rotate_q;
	logic [2:0]      cmd_idx_q;
	logic            in_data_q;
	logic [PGW-1:0]  page_q;
	logic [XW-1:0]   col_q;
	logic [2:0]      bit_q;
	logic [AW-1:0]   clr_q;
	logic            mem [DEPTH];
	logic            mem_q;
	logic            row_ok_s1;
	logic            rd_s1;
	logic [7:0]      byte_q;
	logic            done_q;
	result_t         result_q;

	logic [SYW-1:0]  sy;
	logic            sy_ok;
	logic [SYW-1:0]  ry_full;
	logic [XW-1:0]   rx;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wr_addr;
	logic            pix_in_range;
	logic            mem_we;
	logic            mem_wdata;
	logic [AW-1:0]   mem_addr;
	logic            pix_bit;
	logic [7:0]      packed_byte;
	logic [7:0]      cmd_byte;
	logic            last_col;
	logic            last_page;

	// Display row of the bit being gathered, and the stored pixel it maps to.
	assign sy      = {page_q, bit_q};
	assign sy_ok   = ({1'b0, sy} < (SYW + 1)'(HEIGHT));
	assign ry_full = rotate_q ? (SYW'(HEIGHT - 1) - sy) : sy;
	assign rx      = rotate_q ? (XW'(WIDTH - 1) - col_q) : col_q;
	assign rd_addr = {ry_full[YW-1:0], rx};

	assign wr_addr      = {item_q.pixel_y[YW-1:0], item_q.pixel_x[XW-1:0]};
	assign pix_in_range = ({1'b0, item_q.pixel_x} < 9'(WIDTH)) &&
	                      ({1'b0, item_q.pixel_y} < 7'(HEIGHT));

	assign mem_we    = ctrl.clr_step || (ctrl.pix_write && pix_in_range);
	assign mem_wdata = ctrl.clr_step ? 1'b0 : item_q.pixel_on;
	assign mem_addr  = ctrl.clr_step ? clr_q : (ctrl.pix_write ? wr_addr : rd_addr);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		mem_q     <= mem[mem_addr];
		row_ok_s1 <= sy_ok;
	end

	// Rows past the bottom of the panel pack as off bits.
	assign pix_bit     = mem_q && row_ok_s1;
	assign packed_byte = {pix_bit, byte_q[7:1]};

	assign last_col  = (col_q == XW'(WIDTH - 1));
	assign last_page = (page_q == PGW'(PAGES - 1));

	always_comb begin
		unique case (cmd_idx_q)
			CMD_COL_OP:     cmd_byte = OPC_COL_RANGE;
			CMD_COL_START:  cmd_byte = 8'd0;
			CMD_COL_END:    cmd_byte = 8'(WIDTH - 1);
			CMD_PAGE_OP:    cmd_byte = OPC_PAGE_RANGE;
			CMD_PAGE_START: cmd_byte = 8'd0;
			CMD_PAGE_END:   cmd_byte = 8'(PAGES - 1);
			default:        cmd_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			item_q <= item;
		end
		if (rd_s1) begin
			byte_q <= packed_byte;
		end
		if (ctrl.emit_cmd) begin
			result_q <= '{out_byte: cmd_byte, is_data: 1'b0, last_of_frame: 1'b0};
		end else if (ctrl.emit_data) begin
			result_q <= '{out_byte: packed_byte, is_data: 1'b1,
			              last_of_frame: last_col && last_page};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotate_q  <= 1'b0;
			cmd_idx_q <= CMD_COL_OP;
			in_data_q <= 1'b0;
			page_q    <= '0;
			col_q     <= '0;
			bit_q     <= '0;
			clr_q     <= '0;
			rd_s1     <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				rotate_q <= cfg_data;
			end
			rd_s1  <= ctrl.rd_step;
			done_q <= ctrl.emit_cmd || ctrl.emit_data;
			if (ctrl.clr_init) begin
				clr_q <= '0;
			end else if (ctrl.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ctrl.load) begin
				bit_q <= '0;
			end else if (ctrl.rd_step) begin
				bit_q <= bit_q + 1'b1;
			end
			if (ctrl.emit_cmd) begin
				if (cmd_idx_q == CMD_PAGE_END) begin
					cmd_idx_q <= CMD_COL_OP;
					in_data_q <= 1'b1;
					page_q    <= '0;
					col_q     <= '0;
				end else begin
					cmd_idx_q <= cmd_idx_q + 1'b1;
				end
			end else if (ctrl.emit_data) begin
				if (last_col) begin
					col_q <= '0;
					if (last_page) begin
						in_data_q <= 1'b0;
						page_q    <= '0;
					end else begin
						page_q <= page_q + 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	assign stat.in_data  = in_data_q;
	assign stat.clr_last = &clr_q;
	assign stat.bit_last = (bit_q == 3'd7);
	assign done          = done_q;
	assign result        = result_q;

endmodule

[src/oled_page_framebuffer_packer.sv]
// Top level of the OLED page framebuffer packer: controller and datapath.
//
// Channel   Direction  Handshake                 Payload
// item      in         start high, busy low      ofp_pkg::item_t
// result    out        done high for one cycle   ofp_pkg::result_t
// config    in         cfg_we high               cfg_data (rotate_180)
//
// A pixel write holds busy for a single state and raises no done; a command byte
// is sent from its own busy state, with done in the cycle after. A data byte reads
// its eight pixels one at a time from the single-port pixel store, then emits the
// byte from a finish state. A clear sweeps the store one pixel a cycle over all
// 2**(clog2(WIDTH)+clog2(HEIGHT)) pixels; the same sweep runs after reset, busy high.
// The receiver cannot stall; done is a one-cycle strobe.
module oled_page_framebuffer_packer #(
	parameter int WIDTH  = 128,
	parameter int HEIGHT = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ofp_pkg::item_t   item,
	input  logic             cfg_we,
	input  logic             cfg_data,
	output logic             done,
	output ofp_pkg::result_t result
);
	import ofp_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	ofp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.stat   (stat),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	ofp_datapath #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.ctrl     (ctrl),
		.stat     (stat),
		.done     (done),
		.result   (result)
	);

endmodule

[src/ofp_checker.sv]
// Port-level checks for the OLED page framebuffer packer, bound to the top level.
module ofp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input ofp_pkg::item_t   item,
	input logic             cfg_we,
	input logic             done,
	input ofp_pkg::result_t result
);
	import ofp_pkg::*;

	// Every accepted transaction of a used kind occupies the block.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.kind == KIND_WRITE || item.kind == KIND_CLEAR ||
		 item.kind == KIND_SEND)) |=> busy)
		else $error("accepted transaction did not raise busy");

	// A result always follows a busy cycle of its own.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.last_of_frame) |-> result.is_data)
		else $error("end of frame marked on a command byte");

	// Config writes while idle never disturb the idle handshake.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && !busy && !start) |=> !busy)
		else $error("configuration write started work");

endmodule

bind oled_page_framebuffer_packer ofp_checker u_checker (.*);
